// ===== rtl/hcb_pkg.sv =====
// Package for the Hill cipher block unit: widths, codes, constants and shared types.
// Used by hcb_front, hcb_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package hcb_pkg;

    localparam int N_DEF       = 3;
    localparam int LETTER_W    = 5;
    localparam int KEY_W_MAX   = 45;
    localparam int JOB_DEPTH   = 2;
    localparam int OUT_DEPTH   = 4;
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 16;

    localparam logic [LETTER_W-1:0]  PAD_LETTER   = 5'd23;
    localparam logic [LETTER_W-1:0]  MOD_BASE     = 5'd26;
    localparam logic [RECIP_W-1:0]   RECIP_26     = 12'd2521;
    localparam logic [KEY_W_MAX-1:0] IDENTITY_KEY = 45'd1099512676353;

    localparam logic CFG_KEY     = 1'b0;
    localparam logic CFG_INV_KEY = 1'b1;

    typedef struct packed {
        logic dec;
        logic err;
    } t_job_ctl;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                length_error;
    } t_result;

endpackage

// ===== rtl/hcb_fifo.sv =====
// Small register FIFO used for the job queue and the result queue.
// Depends on nothing; DEPTH must be a power of two.
`timescale 1ns / 1ps

module hcb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/hcb_front.sv =====
// Front end: gathers letters into a block and classifies each finished block as a job.
// Depends on hcb_pkg.
`timescale 1ns / 1ps

module hcb_front import hcb_pkg::*; #(
    parameter int N = N_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_cmd,
    input  logic [LETTER_W-1:0]   i_letter,
    input  logic                  i_end_of_message,
    input  logic                  i_job_full,
    output logic                  o_job_push,
    output logic [N*LETTER_W-1:0] o_job_letters,
    output t_job_ctl              o_job_ctl
);

    localparam int CNT_W = $clog2(N);

    logic [LETTER_W-1:0] r_buf [N];
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    n_fill;
    logic                accept;
    logic                complete;

    assign o_full   = i_job_full;
    assign accept   = i_push && !i_job_full;
    assign complete = (r_fill == CNT_W'(N - 1));

    assign o_job_push    = accept && (complete || i_end_of_message);
    assign o_job_ctl.dec = complete && i_cmd;
    assign o_job_ctl.err = !complete && i_cmd;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (CNT_W'(i) < r_fill) begin
                o_job_letters[i*LETTER_W +: LETTER_W] = r_buf[i];
            end else if (CNT_W'(i) == r_fill) begin
                o_job_letters[i*LETTER_W +: LETTER_W] = i_letter;
            end else begin
                o_job_letters[i*LETTER_W +: LETTER_W] = PAD_LETTER;
            end
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            if (o_job_push) begin
                n_fill = '0;
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf[r_fill] <= i_letter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

// ===== rtl/hcb_back.sv =====
// Back end: key registers, a column per cycle unless stalled, and a mod 26 reduction pipeline.
// Depends on hcb_pkg.
`timescale 1ns / 1ps

module hcb_back import hcb_pkg::*; #(
    parameter int N = N_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [LETTER_W*N*N-1:0]        i_cfg_data,
    input  logic                           i_job_empty,
    input  logic [N*LETTER_W-1:0]          i_job_letters,
    input  t_job_ctl                       i_job_ctl,
    output logic                           o_job_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_res_push,
    output t_result                        o_res
);

    localparam int KEY_W  = LETTER_W * N * N;
    localparam int CNT_W  = $clog2(N);
    localparam int SUM_W  = 2 * LETTER_W + $clog2(N);
    localparam int Q_W    = SUM_W - 4;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int OC_W   = $clog2(OUT_DEPTH + 1) + 1;

    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_inv_key;
    logic [KEY_W-1:0]  mat;
    logic [CNT_W-1:0]  r_col;
    logic [SUM_W-1:0]  col_sum;
    logic              col_last;
    logic              issue;
    logic [OC_W-1:0]   in_use;

    logic              r_s1_v;
    logic [SUM_W-1:0]  r_s1_sum;
    logic              r_s1_last;
    logic              r_s1_err;

    logic              r_s2_v;
    logic [SUM_W-1:0]  r_s2_sum;
    logic [Q_W-1:0]    r_s2_q;
    logic              r_s2_last;
    logic              r_s2_err;

    logic [PROD_W-1:0] recip_prod;
    logic [SUM_W-1:0]  rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= IDENTITY_KEY[KEY_W-1:0];
            r_inv_key <= IDENTITY_KEY[KEY_W-1:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY:     r_key     <= i_cfg_data;
                CFG_INV_KEY: r_inv_key <= i_cfg_data;
                default:     r_key     <= r_key;
            endcase
        end
    end

    assign mat      = i_job_ctl.dec ? r_inv_key : r_key;
    assign col_last = (r_col == CNT_W'(N - 1));
    assign in_use   = OC_W'(i_out_count) + OC_W'(r_s1_v) + OC_W'(r_s2_v);
    assign issue    = !i_job_empty && (in_use < OC_W'(OUT_DEPTH));
    assign o_job_pop = issue && (i_job_ctl.err || col_last);

    always_comb begin
        col_sum = '0;
        for (int j = 0; j < N; j++) begin
            col_sum = col_sum
                + SUM_W'(i_job_letters[j*LETTER_W +: LETTER_W])
                * SUM_W'(mat[LETTER_W*(j*N + int'(r_col)) +: LETTER_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            if (issue && !i_job_ctl.err) begin
                r_col <= col_last ? '0 : r_col + 1'b1;
            end
        end
    end

    assign recip_prod = PROD_W'(r_s1_sum) * PROD_W'(RECIP_26);

    always_ff @(posedge i_clk) begin
        r_s1_sum  <= i_job_ctl.err ? '0 : col_sum;
        r_s1_last <= i_job_ctl.err || col_last;
        r_s1_err  <= i_job_ctl.err;
        r_s2_sum  <= r_s1_sum;
        r_s2_q    <= recip_prod[RECIP_SHIFT +: Q_W];
        r_s2_last <= r_s1_last;
        r_s2_err  <= r_s1_err;
    end

    assign rem = r_s2_sum - SUM_W'(r_s2_q) * SUM_W'(MOD_BASE);

    assign o_res_push          = r_s2_v;
    assign o_res.letter        = rem[LETTER_W-1:0];
    assign o_res.last          = r_s2_last;
    assign o_res.length_error  = r_s2_err;

endmodule

// ===== rtl/hill_cipher_block_mod26.sv =====
// Top level of the Hill cipher block unit (mod 26): front end, job queue, back end, result queue.
// Depends on hcb_pkg, hcb_fifo, hcb_front and hcb_back.
//
//   Channel   Handshake           Payload
//   input     push / full         i_cmd, i_letter, i_end_of_message
//   result    empty / pop         o_letter_out, o_last, o_length_error
//   config    i_cfg_we            i_cfg_index, i_cfg_data
//
// One letter is taken per cycle while full is low. The back end computes one result column
// per cycle while a job is waiting and the result queue has room, so a block of N letters
// yields N results, each registered in the s1 and s2 stages before the result queue.
// Reset is synchronous; the keys return to the identity matrix.
// Each queue lets its side stall on its own; a long hold on the result side fills
// both queues and then stops the input.
`timescale 1ns / 1ps

module hill_cipher_block_mod26 import hcb_pkg::*; #(
    parameter int N = N_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [LETTER_W*N*N-1:0] i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_cmd,
    input  logic [LETTER_W-1:0]     i_letter,
    input  logic                    i_end_of_message,
    output logic                    empty,
    input  logic                    pop,
    output logic [LETTER_W-1:0]     o_letter_out,
    output logic                    o_last,
    output logic                    o_length_error
);

    localparam int JOB_W = N * LETTER_W + $bits(t_job_ctl);

    logic                           job_full;
    logic                           job_push;
    logic [N*LETTER_W-1:0]          job_letters_in;
    t_job_ctl                       job_ctl_in;
    logic [JOB_W-1:0]               job_head;
    logic                           job_empty;
    logic                           job_pop;
    logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
    logic                           res_push;
    t_result                        res_in;
    t_result                        res_head;
    logic                           res_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] res_count;

    hcb_front #(.N(N)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_cmd            (i_cmd),
        .i_letter         (i_letter),
        .i_end_of_message (i_end_of_message),
        .i_job_full       (job_full),
        .o_job_push       (job_push),
        .o_job_letters    (job_letters_in),
        .o_job_ctl        (job_ctl_in)
    );

    hcb_fifo #(.WIDTH(JOB_W), .DEPTH(JOB_DEPTH)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  ({job_letters_in, job_ctl_in}),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (job_empty),
        .o_count (job_count)
    );

    hcb_back #(.N(N)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_job_empty   (job_empty || (job_count == '0)),
        .i_job_letters (job_head[JOB_W-1:$bits(t_job_ctl)]),
        .i_job_ctl     (t_job_ctl'(job_head[$bits(t_job_ctl)-1:0])),
        .o_job_pop     (job_pop),
        .i_out_count   (res_count),
        .o_res_push    (res_push),
        .o_res         (res_in)
    );

    hcb_fifo #(.WIDTH($bits(t_result)), .DEPTH(OUT_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !res_full),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_letter_out   = res_head.letter;
    assign o_last         = res_head.last;
    assign o_length_error = res_head.length_error;

endmodule
